FILE: sv/tmrq_pkg.sv
// ----------------------------------------------------------------------------
// tmrq_pkg
// Types and constants shared by the timed memory request queue.
// ----------------------------------------------------------------------------
package tmrq_pkg;

  localparam int OP_W      = 2;
  localparam int REQ_W     = 3;
  localparam int ADDR_W    = 64;
  localparam int SIZE_W    = 16;
  localparam int TAG_W     = 16;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int BUF_W     = 5;
  localparam int TIME_W    = 16;
  localparam int LINE_W    = 13;
  localparam int CYCLE_W   = 64;
  localparam int SPAN_W    = 17;
  localparam int PROD_W    = SPAN_W + TIME_W;

  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_REPLY  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ISSUE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_TIME     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_PER_LINE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES    = 2'd3;

  typedef struct packed {
    logic              is_write;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
    logic [REQ_W-1:0]  requester;
  } entry_info_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    entry_info_t       info;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              accepted;
    logic              busy_res;
    logic [REQ_W-1:0]  out_requester;
    logic [ADDR_W-1:0] out_address;
    logic [SIZE_W-1:0] out_size;
    logic [TAG_W-1:0]  out_tag;
    logic              is_write;
    logic              last;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REPLY,
    S_COMPL,
    S_IRD,
    S_ISSUE,
    S_MUL,
    S_DSTART,
    S_DIV,
    S_STATUS
  } state_t;

endpackage

FILE: sv/tmrq_if.sv
// ----------------------------------------------------------------------------
// tmrq_if
// Valid/ready channels of the timed memory request queue.
// ----------------------------------------------------------------------------
interface tmrq_in_if;
  import tmrq_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [REQ_W-1:0]  requester;
  logic [ADDR_W-1:0] address;
  logic [SIZE_W-1:0] size_bytes;
  logic [TAG_W-1:0]  tag;
  logic              snoop_ok;
  logic              sink_ready;

  modport source (
    output valid, op, requester, address, size_bytes, tag, snoop_ok, sink_ready,
    input  ready
  );
  modport sink (
    input  valid, op, requester, address, size_bytes, tag, snoop_ok, sink_ready,
    output ready
  );
endinterface

interface tmrq_out_if;
  import tmrq_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic              accepted;
  logic              busy_res;
  logic [REQ_W-1:0]  out_requester;
  logic [ADDR_W-1:0] out_address;
  logic [SIZE_W-1:0] out_size;
  logic [TAG_W-1:0]  out_tag;
  logic              is_write;
  logic              last;

  modport source (
    output valid, kind, accepted, busy_res, out_requester, out_address, out_size,
           out_tag, is_write, last,
    input  ready
  );
  modport sink (
    input  valid, kind, accepted, busy_res, out_requester, out_address, out_size,
           out_tag, is_write, last,
    output ready
  );
endinterface

interface tmrq_cfg_if;
  import tmrq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/tmrq_ram.sv
// ----------------------------------------------------------------------------
// tmrq_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tmrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/tmrq_div.sv
// ----------------------------------------------------------------------------
// tmrq_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tmrq_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;
  logic             fit;

  always_comb begin
    shifted = {rem, quot[NUM_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den};
    fit     = !diff[DEN_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= num;
    end else if (busy) begin
      rem  <= fit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], fit};
    end
  end

endmodule

FILE: sv/timed_memory_request_queue.sv
// A request reply passes through the REPLY state and then the output register.
// A tick that issues an entry, also after a completion, emits the issue result and then
// waits on the bit-serial divider for the completion time before its status result.
// One transaction is in flight at a time; the next is taken while the last result waits.
// Reset clears pointers, count, cycle counter and configuration to defaults;
// queue memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// timed_memory_request_queue
// Bounded FIFO of memory requests held in RAM, completed after a timed latency.
// ----------------------------------------------------------------------------
module timed_memory_request_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  tmrq_in_if.sink    req,
  tmrq_out_if.source rsp,
  tmrq_cfg_if.sink   cfg
);
  import tmrq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = (CW > BUF_W) ? CW : BUF_W;

  state_t state, state_next;

  logic [BUF_W-1:0]   buffer_size;
  logic [TIME_W-1:0]  base_time;
  logic [TIME_W-1:0]  time_per_line;
  logic [LINE_W-1:0]  line_bytes;

  logic [IW-1:0]      head_ptr;
  logic [CW-1:0]      entry_count;
  logic               head_started;
  logic [CYCLE_W-1:0] head_done_cycle;
  logic [CYCLE_W-1:0] cycle_now;

  logic [CYCLE_W-1:0] tick_now;
  logic               tick_busy;
  logic               tick_ok;
  logic               reply_ok;

  logic               out_valid;
  result_t            res, res_next;

  logic [SPAN_W-1:0]  span;
  logic [LINE_W-1:0]  line_div;
  logic [PROD_W-1:0]  prod;
  logic               div_done;
  logic [PROD_W-1:0]  quot;

  logic               in_fire;
  logic               out_free;
  logic               emit;
  logic               is_req;
  logic               head_due;
  logic               head_wait;
  logic               room;
  logic               ok;
  logic [LW-1:0]      limit;
  logic [IW:0]        tail_sum;
  logic [IW-1:0]      tail_idx;
  logic [LINE_W-1:0]  line_eff;
  entry_t             wr_entry;
  entry_t             rd_entry;

  tmrq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (in_fire && is_req && ok),
    .waddr (tail_idx),
    .wdata (wr_entry),
    .raddr (head_ptr),
    .rdata (rd_entry)
  );

  tmrq_div #(
    .NUM_W (PROD_W),
    .DEN_W (LINE_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DSTART),
    .num   (prod),
    .den   (line_div),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    in_fire   = req.valid && req.ready;
    out_free  = !out_valid || rsp.ready;
    is_req    = (req.op == OP_READ) || (req.op == OP_WRITE);
    head_due  = (entry_count != '0) && head_started && (cycle_now >= head_done_cycle);
    head_wait = (entry_count != '0) && !head_started;

    if ((buffer_size == '0) || (LW'(buffer_size) > LW'(QUEUE_DEPTH))) begin
      limit = LW'(QUEUE_DEPTH);
    end else begin
      limit = LW'(buffer_size);
    end
    room = LW'(entry_count) < limit;
    ok   = room && !((req.op == OP_WRITE) && !req.snoop_ok);

    tail_sum = (IW+1)'(head_ptr) + (IW+1)'(entry_count);
    if (tail_sum >= (IW+1)'(QUEUE_DEPTH)) begin
      tail_idx = IW'(tail_sum - (IW+1)'(QUEUE_DEPTH));
    end else begin
      tail_idx = IW'(tail_sum);
    end

    wr_entry.address        = req.address;
    wr_entry.info.is_write  = (req.op == OP_WRITE);
    wr_entry.info.tag       = req.tag;
    wr_entry.info.size      = req.size_bytes;
    wr_entry.info.requester = req.requester;

    line_eff = (line_bytes == '0) ? LINE_W'(1) : line_bytes;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (req.op) inside
            OP_READ, OP_WRITE: state_next = S_REPLY;
            OP_TICK: begin
              if (head_due) begin
                state_next = req.sink_ready ? S_COMPL : S_STATUS;
              end else if (head_wait) begin
                state_next = S_ISSUE;
              end else begin
                state_next = S_STATUS;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_REPLY:  if (out_free) state_next = S_IDLE;
      S_COMPL: begin
        if (out_free) begin
          state_next = (entry_count > CW'(1)) ? S_IRD : S_STATUS;
        end
      end
      S_IRD:    state_next = S_ISSUE;
      S_ISSUE:  if (out_free) state_next = S_MUL;
      S_MUL:    state_next = S_DSTART;
      S_DSTART: state_next = S_DIV;
      S_DIV:    if (div_done) state_next = S_STATUS;
      S_STATUS: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == S_IDLE);
    cfg.ready = 1'b1;
    emit      = 1'b0;
    res_next  = '0;
    unique case (state)
      S_REPLY: begin
        emit              = out_free;
        res_next.kind     = KIND_REPLY;
        res_next.accepted = reply_ok;
        res_next.last     = 1'b1;
      end
      S_COMPL, S_ISSUE: begin
        emit                   = out_free;
        res_next.kind          = (state == S_COMPL) ? KIND_DONE : KIND_ISSUE;
        res_next.busy_res      = tick_busy;
        res_next.out_requester = rd_entry.info.requester;
        res_next.out_address   = rd_entry.address;
        res_next.out_size      = rd_entry.info.size;
        res_next.out_tag       = rd_entry.info.tag;
        res_next.is_write      = rd_entry.info.is_write;
      end
      S_STATUS: begin
        emit              = out_free;
        res_next.kind     = KIND_STATUS;
        res_next.accepted = tick_ok;
        res_next.busy_res = tick_busy;
        res_next.last     = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  assign rsp.valid         = out_valid;
  assign rsp.kind          = res.kind;
  assign rsp.accepted      = res.accepted;
  assign rsp.busy_res      = res.busy_res;
  assign rsp.out_requester = res.out_requester;
  assign rsp.out_address   = res.out_address;
  assign rsp.out_size      = res.out_size;
  assign rsp.out_tag       = res.out_tag;
  assign rsp.is_write      = res.is_write;
  assign rsp.last          = res.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      head_ptr        <= '0;
      entry_count     <= '0;
      head_started    <= 1'b0;
      head_done_cycle <= '0;
      cycle_now       <= '0;
      buffer_size     <= '0;
      base_time       <= TIME_W'(1);
      time_per_line   <= TIME_W'(1);
      line_bytes      <= LINE_W'(64);
    end else begin
      state <= state_next;

      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          CFG_BUFFER_SIZE:   buffer_size   <= cfg.data[BUF_W-1:0];
          CFG_BASE_TIME:     base_time     <= cfg.data[TIME_W-1:0];
          CFG_TIME_PER_LINE: time_per_line <= cfg.data[TIME_W-1:0];
          CFG_LINE_BYTES:    line_bytes    <= cfg.data[LINE_W-1:0];
        endcase
      end

      if (in_fire && is_req && ok) begin
        entry_count <= entry_count + CW'(1);
      end

      if (in_fire && (req.op == OP_TICK)) begin
        cycle_now <= cycle_now + CYCLE_W'(1);
      end

      if ((state == S_COMPL) && out_free) begin
        head_ptr     <= (head_ptr == IW'(QUEUE_DEPTH - 1)) ? '0 : head_ptr + IW'(1);
        entry_count  <= entry_count - CW'(1);
        head_started <= 1'b0;
      end

      if ((state == S_DIV) && div_done) begin
        head_started    <= 1'b1;
        head_done_cycle <= tick_now + CYCLE_W'(CYCLE_W'(base_time) + CYCLE_W'(quot));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= res_next;
    end
    if (in_fire) begin
      reply_ok  <= ok;
      tick_now  <= cycle_now;
      tick_busy <= (entry_count != '0);
      tick_ok   <= !(head_due && !req.sink_ready);
    end
    if ((state == S_ISSUE) && out_free) begin
      span     <= SPAN_W'(rd_entry.info.size) + SPAN_W'(line_eff) - SPAN_W'(1);
      line_div <= line_eff;
    end
    if (state == S_MUL) begin
      prod <= PROD_W'(time_per_line) * PROD_W'(span);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_started_nonempty: assert property (@(posedge clk) disable iff (rst)
    head_started |-> (entry_count != '0))
    else $error("head marked started on an empty queue");

  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (req.op == OP_TICK)) |=> (cycle_now == $past(cycle_now) + CYCLE_W'(1)))
    else $error("cycle counter did not advance on tick");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_req && (entry_count == CW'(QUEUE_DEPTH)))
      |=> (entry_count == $past(entry_count)))
    else $error("request queued into a full queue");

endmodule
